// ----- src/nfc_pkg.sv -----
// ----------------------------------------------------------------------------
// nfc_pkg: shared types and constants for the NMEA frame checker
// Byte codes, report codes, the frame state and the per-word result.
// ----------------------------------------------------------------------------
`default_nettype none

package nfc_pkg;

    localparam int unsigned LEN_W = 7;
    localparam int unsigned SUM_W = 8;

    localparam logic [7:0]       CH_START       = 8'h24;
    localparam logic [7:0]       CH_STAR        = 8'h2A;
    localparam logic [LEN_W-1:0] LEN_MAX        = 7'd127;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 7'd100;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_GOOD     = 2'd1;
    localparam logic [1:0] ST_BAD_SUM  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_BODY = 4'b0010,
        PH_DIG1 = 4'b0100,
        PH_DIG2 = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [SUM_W-1:0]  sum;
        logic [LEN_W-1:0]  len;
        logic [3:0]        first_digit;
        logic              first_ok;
    } frame_state_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SUM_W-1:0]  sum;
        logic [LEN_W-1:0]  len;
    } frame_result_t;

endpackage

`default_nettype wire

// ----- src/nmea_frame_checker.sv -----
// ----------------------------------------------------------------------------
// nmea_frame_checker: NMEA sentence framing and XOR checksum check
// Finds '$'-started sentences, checks the hex checksum after '*', drops
// frames longer than max_length, and reports one status word per byte.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_byte_in[7:0]
//   m_       out  m_valid/m_ready    m_status[1:0] m_computed_sum[7:0]
//                                    m_frame_length[6:0]
//   cfg_     in   cfg_we             cfg_wr_data[6:0] (max_length)
//
// One word per clock while m_ready stays high; input register, then parse
// into the result register, which also updates the frame state.
// Synchronous active-low reset: frame state cleared, max_length = 100.
// A stalled result holds; the input register still takes a word whenever
// the parse stage moves, so there is no bubble while m_ready stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [7:0]       m_computed_sum,
    output logic [6:0]       m_frame_length,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wr_data
);

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          out_valid_reg;
    nfc_pkg::frame_result_t        out_reg;
    nfc_pkg::frame_state_t         state_reg;
    nfc_pkg::frame_state_t         state_next;
    nfc_pkg::frame_result_t        result_next;
    logic [nfc_pkg::LEN_W-1:0]     max_length_reg;
    logic                          parse_fire;

    assign parse_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || parse_fire;

    nfc_parse u_parse (
        .cur        (state_reg),
        .byte_in    (in_byte_reg),
        .max_length (max_length_reg),
        .nxt        (state_next),
        .res        (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_length_reg <= nfc_pkg::MAX_LENGTH_RST;
            state_reg      <= '{phase: nfc_pkg::PH_HUNT, sum: '0, len: '0,
                                first_digit: 4'h0, first_ok: 1'b0};
        end else begin
            if (cfg_we) begin
                max_length_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (parse_fire) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_byte_in;
        end
        if (parse_fire) begin
            out_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_reg.status;
    assign m_computed_sum = out_reg.sum;
    assign m_frame_length = out_reg.len;

    a_hunt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == nfc_pkg::PH_HUNT |-> state_reg.sum == '0 && state_reg.len == '0)
        else $error("hunt phase with nonzero sum or length");

    a_dig2_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        parse_fire && state_reg.phase == nfc_pkg::PH_DIG2
        |=> state_reg.phase == nfc_pkg::PH_HUNT
            && (m_status == nfc_pkg::ST_GOOD || m_status == nfc_pkg::ST_BAD_SUM))
        else $error("second digit did not close the frame");

    a_fire_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        parse_fire |=> m_valid)
        else $error("parsed word not presented");

endmodule

`default_nettype wire

// ----- src/nfc_parse.sv -----
// ----------------------------------------------------------------------------
// nfc_parse: per-word frame parser
// Next frame state and report for one received word, from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module nfc_parse (
    input  wire nfc_pkg::frame_state_t          cur,
    input  wire logic [7:0]                     byte_in,
    input  wire logic [nfc_pkg::LEN_W-1:0]      max_length,
    output nfc_pkg::frame_state_t               nxt,
    output nfc_pkg::frame_result_t              res
);

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                hex_value = {1'b1, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
                hex_value = {1'b1, d[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
                hex_value = {1'b1, d[3:0]};
            end else begin
                hex_value = 5'b0_0000;
            end
        end
    endfunction

    logic [nfc_pkg::LEN_W-1:0] len_inc;
    logic [4:0]                hex;
    logic [7:0]                expected;
    logic                      end_frame;

    assign len_inc = (cur.len == nfc_pkg::LEN_MAX) ? nfc_pkg::LEN_MAX
                                                   : cur.len + 7'd1;
    assign hex     = hex_value(byte_in);
    assign expected = (hex[4] && cur.first_ok) ? {cur.first_digit, hex[3:0]} : 8'h00;

    always_comb begin
        nxt        = cur;
        res.status = nfc_pkg::ST_NONE;
        end_frame  = 1'b0;
        unique case (cur.phase)
            nfc_pkg::PH_BODY: begin
                if (byte_in == nfc_pkg::CH_START) begin
                    nxt.sum = '0;
                    nxt.len = 7'd1;
                end else if (byte_in == nfc_pkg::CH_STAR) begin
                    nxt.len   = len_inc;
                    nxt.phase = nfc_pkg::PH_DIG1;
                end else begin
                    nxt.len = len_inc;
                    nxt.sum = cur.sum ^ byte_in;
                    if (len_inc > max_length) begin
                        res.status = nfc_pkg::ST_TOO_LONG;
                        end_frame  = 1'b1;
                    end
                end
            end
            nfc_pkg::PH_DIG1: begin
                nxt.first_ok    = hex[4];
                nxt.first_digit = hex[3:0];
                nxt.len         = len_inc;
                nxt.phase       = nfc_pkg::PH_DIG2;
            end
            nfc_pkg::PH_DIG2: begin
                nxt.len    = len_inc;
                res.status = (expected == cur.sum) ? nfc_pkg::ST_GOOD : nfc_pkg::ST_BAD_SUM;
                end_frame  = 1'b1;
            end
            default: begin
                nxt.phase = nfc_pkg::PH_HUNT;
                if (byte_in == nfc_pkg::CH_START) begin
                    nxt.phase = nfc_pkg::PH_BODY;
                    nxt.sum   = '0;
                    nxt.len   = 7'd1;
                end
            end
        endcase
        res.sum = nxt.sum;
        res.len = nxt.len;
        if (end_frame) begin
            nxt.phase       = nfc_pkg::PH_HUNT;
            nxt.sum         = '0;
            nxt.len         = '0;
            nxt.first_digit = 4'h0;
            nxt.first_ok    = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_nmea_frame_checker.sv -----
// ----------------------------------------------------------------------------
// tb_nmea_frame_checker: self-checking bench for the NMEA frame checker
// Feeds byte words through the s_ channel: directed sentences first, then
// random well-formed, corrupted and truncated sentences mixed with noise,
// across several max_length settings. A behavioral predictor tracks the
// frame state and every m_ word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_nmea_frame_checker;

    timeunit 1ns;
    timeprecision 1ps;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_in = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_status;
    logic [7:0] m_computed_sum;
    logic [6:0] m_frame_length;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_wr_data = 7'd0;

    nmea_frame_checker i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_in      (s_byte_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_computed_sum (m_computed_sum),
        .m_frame_length (m_frame_length),
        .cfg_we         (cfg_we),
        .cfg_wr_data    (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    logic [7:0]             rx_bytes_q[$];
    nfc_pkg::frame_result_t expected_reports[$];
    int unsigned            fail_count = 0;
    bit                     idle_en = 1'b1;
    int unsigned            hold_req = 0;

    // predictor state
    nfc_pkg::phase_t                 ph = nfc_pkg::PH_HUNT;
    logic [nfc_pkg::SUM_W-1:0]       acc_sum = '0;
    logic [nfc_pkg::LEN_W-1:0]       acc_len = '0;
    logic [3:0]                      hi_nib = '0;
    logic                            hi_ok = 1'b0;
    logic [nfc_pkg::LEN_W-1:0]       max_len_set = nfc_pkg::MAX_LENGTH_RST;

    function automatic logic [nfc_pkg::LEN_W-1:0] len_step(logic [nfc_pkg::LEN_W-1:0] n);
        return (n == nfc_pkg::LEN_MAX) ? n : n + 7'd1;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 4'd10) return 8'("0") + 8'(n);
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    function automatic nfc_pkg::frame_result_t sentence_step(logic [7:0] b);
        nfc_pkg::frame_result_t r;
        logic [4:0]             d;
        logic [7:0]             want;
        logic                   done;
        r.status = nfc_pkg::ST_NONE;
        done = 1'b0;
        case (ph)
            nfc_pkg::PH_HUNT: begin
                if (b == nfc_pkg::CH_START) begin
                    ph = nfc_pkg::PH_BODY;
                    acc_sum = '0;
                    acc_len = 7'd1;
                end
            end
            nfc_pkg::PH_BODY: begin
                if (b == nfc_pkg::CH_START) begin
                    acc_sum = '0;
                    acc_len = 7'd1;
                end else if (b == nfc_pkg::CH_STAR) begin
                    acc_len = len_step(acc_len);
                    ph = nfc_pkg::PH_DIG1;
                end else begin
                    acc_len = len_step(acc_len);
                    acc_sum = acc_sum ^ b;
                    if (acc_len > max_len_set) begin
                        r.status = nfc_pkg::ST_TOO_LONG;
                        done = 1'b1;
                    end
                end
            end
            nfc_pkg::PH_DIG1: begin
                d = hex_decode(b);
                hi_nib = d[3:0];
                hi_ok = d[4];
                acc_len = len_step(acc_len);
                ph = nfc_pkg::PH_DIG2;
            end
            default: begin
                d = hex_decode(b);
                want = (d[4] && hi_ok) ? {hi_nib, d[3:0]} : 8'h00;
                acc_len = len_step(acc_len);
                r.status = (want == acc_sum) ? nfc_pkg::ST_GOOD : nfc_pkg::ST_BAD_SUM;
                done = 1'b1;
            end
        endcase
        r.sum = acc_sum;
        r.len = acc_len;
        if (done) begin
            ph = nfc_pkg::PH_HUNT;
            acc_sum = '0;
            acc_len = '0;
            hi_nib = '0;
            hi_ok = 1'b0;
        end
        return r;
    endfunction

    // sender
    int unsigned src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_reports.push_back(sentence_step(s_byte_in));
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (rx_bytes_q.size() > 0) begin
                    if (idle_en && $urandom_range(0, 5) == 0) begin
                        src_gap = $urandom_range(1, 8) - 1;
                        s_valid <= 1'b0;
                    end else begin
                        s_valid <= 1'b1;
                        s_byte_in <= rx_bytes_q.pop_front();
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with a long hold-off on request
    int unsigned sink_gap = 0;
    int unsigned hold_left = 0;
    int unsigned hold_seen = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 80;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(1, 8) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin : chk
        nfc_pkg::frame_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected result word: status %0d sum %02h len %0d",
                       m_status, m_computed_sum, m_frame_length);
                fail_count++;
            end else begin
                w = expected_reports.pop_front();
                if (m_status !== w.status) begin
                    $error("status: expected %0d, got %0d", w.status, m_status);
                    fail_count++;
                end
                if (m_computed_sum !== w.sum) begin
                    $error("computed_sum: expected %02h, got %02h", w.sum, m_computed_sum);
                    fail_count++;
                end
                if (m_frame_length !== w.len) begin
                    $error("frame_length: expected %0d, got %0d", w.len, m_frame_length);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_str(string s);
        foreach (s[i]) rx_bytes_q.push_back(s[i]);
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (rx_bytes_q.size() > 0 || s_valid || expected_reports.size() > 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max_length(logic [6:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        max_len_set = v;
    endtask

    // body_force < 0 picks a random body length
    task automatic queue_sentence(input int body_force, output int unsigned n);
        int          body_n;
        int unsigned flavor;
        int unsigned k;
        int unsigned start_sz;
        logic [7:0]  b;
        logic [7:0]  sum;
        start_sz = rx_bytes_q.size();
        repeat ($urandom_range(0, 2)) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
        if (body_force >= 0) begin
            body_n = body_force;
        end else if ($urandom_range(0, 9) == 0) begin
            body_n = int'(max_len_set) + int'($urandom_range(0, 6)) - 3;
            if (body_n < 0) body_n = 0;
        end else begin
            body_n = $urandom_range(0, 12);
        end
        flavor = $urandom_range(0, 9);
        rx_bytes_q.push_back(nfc_pkg::CH_START);
        sum = 8'h00;
        for (k = 0; k < body_n; k++) begin
            do b = 8'($urandom_range(0, 255));
            while (b == nfc_pkg::CH_START || b == nfc_pkg::CH_STAR);
            if (flavor == 8 && k == body_n / 2) begin
                rx_bytes_q.push_back(nfc_pkg::CH_START);
                sum = 8'h00;
            end
            rx_bytes_q.push_back(b);
            sum ^= b;
        end
        if (flavor != 9) begin
            rx_bytes_q.push_back(nfc_pkg::CH_STAR);
            if (flavor == 6) sum ^= 8'(1 << $urandom_range(0, 7));
            if (flavor == 7) begin
                rx_bytes_q.push_back(8'($urandom_range(0, 255)));
                rx_bytes_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                rx_bytes_q.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
                rx_bytes_q.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
            end
        end
        n = rx_bytes_q.size() - start_sz;
    endtask

    task automatic queue_random(int unsigned target);
        int unsigned cnt;
        int unsigned n;
        cnt = 0;
        while (cnt < target) begin
            queue_sentence(-1, n);
            cnt += n;
        end
    endtask

    initial begin
        int unsigned n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset max_length: good, restart, high bytes, bad sum, bad hex
        push_str("$A*41");
        push_str("$$");
        rx_bytes_q.push_back(8'hFF);
        rx_bytes_q.push_back(8'h80);
        push_str("*7f");
        push_str("$B*00");
        push_str("$*$*");

        // drop at the smallest limits; star and digits may pass the limit
        write_max_length(7'd2);
        push_str("$AB");
        write_max_length(7'd0);
        push_str("$A");
        write_max_length(7'd1);
        push_str("$*00");

        // largest limit: length saturation, and a long receiver stall
        write_max_length(7'd127);
        queue_sentence(130, n);
        queue_random(140);
        hold_req++;

        write_max_length(7'd2);
        queue_random(60);

        write_max_length(7'($urandom_range(3, 126)));
        queue_random(140);

        write_max_length(nfc_pkg::MAX_LENGTH_RST);
        queue_random(100);
        wait_idle();
        idle_en = 1'b0;
        queue_random(100);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
